### rtl/assert_macros.svh
// Assertion macros used by the checker in rtl/bsc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, switched off while rst_n is low.
`define BSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds through reset.
`define BSC_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bsc_pkg.sv
// Types, constants and helper functions of the barometric compensation core.
package bsc_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_scaled;
    logic               pressure_invalid;
  } bsc_out_t;

  // calibration words, raw 16-bit patterns, plus trims
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [10:0] temp_trim;
    logic [21:0] press_trim;
  } bsc_coef_t;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM = CFG_IDX_W'(5);

  localparam logic [10:0] TEMP_TRIM_RST  = 11'd1698;     // -350
  localparam logic [21:0] PRESS_TRIM_RST = 22'd3952486;  // -241818

  localparam logic signed [63:0] TEMP_MIN  = -64'sd4000;
  localparam logic signed [63:0] TEMP_MAX  = 64'sd8500;
  localparam logic signed [63:0] PRESS_MAX = 64'sd33554431;
  localparam logic signed [63:0] PRESS_LIM = 64'sh0000_0100_0000_0000;

  localparam int MUL_LAT    = 3;
  localparam int DIV_STAGES = 64;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  // six multiply steps ahead of the divider, two after it, three tail stages
  localparam int CORE_LAT   = 6 * MUL_LAT + DIV_LAT + 2 * MUL_LAT + 3;

  function automatic logic [63:0] asr(input logic [63:0] v, input int unsigned sh);
    return $unsigned($signed(v) >>> sh);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx11(input logic [10:0] v);
    return {{53{v[10]}}, v};
  endfunction

  function automatic logic [63:0] sx22(input logic [21:0] v);
    return {{42{v[21]}}, v};
  endfunction

endpackage

### rtl/bsc_mul_lo.sv
// Pipelined low-half 64x64 multiplier, several lanes, with sideband.
module bsc_mul_lo #(
  parameter int LANES = 1,
  parameter int SW    = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [LANES-1:0][63:0] a,
  input  logic [LANES-1:0][63:0] b,
  input  logic [SW-1:0]          side_in,
  output logic                   out_vld,
  output logic [LANES-1:0][63:0] p,
  output logic [SW-1:0]          side_out
);

  logic [LANES-1:0][63:0] a_r, b_r, ll_r, p_r;
  logic [LANES-1:0][31:0] lh_r, hl_r;
  logic [SW-1:0]          s0_r, s1_r, s2_r;
  logic                   v0_r, v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // operand reg, 32x32 partial products, recombine
  always_ff @(posedge clk) begin
    a_r  <= a;
    b_r  <= b;
    s0_r <= side_in;
    s1_r <= s0_r;
    s2_r <= s1_r;
    for (int i = 0; i < LANES; i++) begin
      ll_r[i] <= 64'(a_r[i][31:0]) * 64'(b_r[i][31:0]);
      lh_r[i] <= 32'(a_r[i][31:0] * b_r[i][63:32]);
      hl_r[i] <= 32'(a_r[i][63:32] * b_r[i][31:0]);
      p_r[i]  <= ll_r[i] + {32'(lh_r[i] + hl_r[i]), 32'b0};
    end
  end

  assign out_vld  = v2_r;
  assign p        = p_r;
  assign side_out = s2_r;

endmodule

### rtl/bsc_front.sv
// Temperature compensation and pressure dividend/divisor, six multiply steps.
module bsc_front import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  bsc_in_t     in_data,
  input  bsc_coef_t   coef,
  output logic        out_vld,
  output logic [63:0] num,
  output logic [31:0] den,
  output logic [14:0] tc
);

  localparam int SA = 20;
  localparam int SB = 20 + 64;
  localparam int SC = 20 + 64;
  localparam int SD = 20 + 3 * 64;
  localparam int SE = 21 + 64 + 15;
  localparam int SF = 32 + 15;

  // step A: (adc_t/8 - 2*T1) * T2 and d*d
  logic [1:0][63:0] a_a, b_a, p_a;
  logic [SA-1:0]    s_a;
  logic             v_a;
  assign a_a[0] = {47'b0, in_data.raw_temperature[19:3]} - {47'b0, coef.t1, 1'b0};
  assign b_a[0] = sx16(coef.t2);
  assign a_a[1] = {48'b0, in_data.raw_temperature[19:4]} - {48'b0, coef.t1};
  assign b_a[1] = a_a[1];

  bsc_mul_lo #(.LANES(2), .SW(SA)) u_mul_a (
    .clk, .rst_n, .in_vld(in_vld), .a(a_a), .b(b_a),
    .side_in(in_data.raw_pressure), .out_vld(v_a), .p(p_a), .side_out(s_a)
  );

  // step B: (d*d >> 12) * T3
  logic [0:0][63:0] a_b, b_b, p_b;
  logic [SB-1:0]    s_b;
  logic             v_b;
  assign a_b[0] = asr(p_a[1], 12);
  assign b_b[0] = sx16(coef.t3);

  bsc_mul_lo #(.LANES(1), .SW(SB)) u_mul_b (
    .clk, .rst_n, .in_vld(v_a), .a(a_b), .b(b_b),
    .side_in({s_a, asr(p_a[0], 11)}), .out_vld(v_b), .p(p_b), .side_out(s_b)
  );

  // step C: fine value, a = fine - 128000; a*a, a*P5, a*P2
  logic [63:0]      fine_c, a_c;
  logic [2:0][63:0] a_cv, b_cv, p_c;
  logic [SC-1:0]    s_c;
  logic             v_c;
  assign fine_c  = s_b[63:0] + asr(p_b[0], 14);
  assign a_c     = fine_c - 64'd128000;
  assign a_cv[0] = a_c;
  assign b_cv[0] = a_c;
  assign a_cv[1] = a_c;
  assign b_cv[1] = sx16(coef.p5);
  assign a_cv[2] = a_c;
  assign b_cv[2] = sx16(coef.p2);

  bsc_mul_lo #(.LANES(3), .SW(SC)) u_mul_c (
    .clk, .rst_n, .in_vld(v_b), .a(a_cv), .b(b_cv),
    .side_in({s_b[SB-1:64], fine_c}), .out_vld(v_c), .p(p_c), .side_out(s_c)
  );

  // step D: a*a*P6, a*a*P3; fine*5 + 128 for the temperature
  logic [63:0]      t5_d;
  logic [1:0][63:0] a_d, b_d, p_d;
  logic [SD-1:0]    s_d;
  logic             v_d;
  assign t5_d   = {s_c[61:0], 2'b0} + s_c[63:0] + 64'd128;
  assign a_d[0] = p_c[0];
  assign b_d[0] = sx16(coef.p6);
  assign a_d[1] = p_c[0];
  assign b_d[1] = sx16(coef.p3);

  bsc_mul_lo #(.LANES(2), .SW(SD)) u_mul_d (
    .clk, .rst_n, .in_vld(v_c), .a(a_d), .b(b_d),
    .side_in({s_c[SC-1:64], t5_d, p_c[1], p_c[2]}),
    .out_vld(v_d), .p(p_d), .side_out(s_d)
  );

  // step E: dividend term b, divisor product, trimmed temperature
  logic [63:0]      ap2_e, ap5_e, t5_e, b_e, tcv_e, pp_e;
  logic [14:0]      tc_e;
  logic [0:0][63:0] a_e, b_ev, p_e;
  logic [SE-1:0]    s_e;
  logic             v_e;
  assign ap2_e = s_d[63:0];
  assign ap5_e = s_d[127:64];
  assign t5_e  = s_d[191:128];
  assign pp_e  = 64'd1048576 - {44'b0, s_d[SD-1:192]};
  assign b_e   = p_d[0] + {ap5_e[46:0], 17'b0} + {{13{coef.p4[15]}}, coef.p4, 35'b0};
  assign a_e[0] = 64'h0000_8000_0000_0000 + asr(p_d[1], 8) + {ap2_e[51:0], 12'b0};
  assign b_ev[0] = {48'b0, coef.p1};
  assign tcv_e = asr(t5_e, 8) + sx11(coef.temp_trim);

  always_comb begin
    if ($signed(tcv_e) < TEMP_MIN) begin
      tc_e = TEMP_MIN[14:0];
    end else if ($signed(tcv_e) > TEMP_MAX) begin
      tc_e = TEMP_MAX[14:0];
    end else begin
      tc_e = tcv_e[14:0];
    end
  end

  bsc_mul_lo #(.LANES(1), .SW(SE)) u_mul_e (
    .clk, .rst_n, .in_vld(v_d), .a(a_e), .b(b_ev),
    .side_in({pp_e[20:0], b_e, tc_e}), .out_vld(v_e), .p(p_e), .side_out(s_e)
  );

  // step F: ((pp << 31) - b) * 3125; divisor is the product >> 33
  logic [63:0]      den_f;
  logic [0:0][63:0] a_f, b_f, p_f;
  logic [SF-1:0]    s_f;
  assign den_f  = asr(p_e[0], 33);
  assign a_f[0] = {12'b0, s_e[SE-1:79], 31'b0} - s_e[78:15];
  assign b_f[0] = 64'd3125;

  bsc_mul_lo #(.LANES(1), .SW(SF)) u_mul_f (
    .clk, .rst_n, .in_vld(v_e), .a(a_f), .b(b_f),
    .side_in({den_f[31:0], s_e[14:0]}), .out_vld(out_vld), .p(p_f), .side_out(s_f)
  );

  assign num = p_f[0];
  assign den = s_f[SF-1:15];
  assign tc  = s_f[14:0];

endmodule

### rtl/bsc_div.sv
// Signed 64 by 32 bit division, one restoring step per pipeline stage.
module bsc_div import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] num,
  input  logic [31:0] den,
  input  logic [14:0] tc_in,
  output logic        out_vld,
  output logic [63:0] quo,
  output logic        inv,
  output logic [14:0] tc_out
);

  logic [63:0] nq_r  [0:DIV_STAGES];
  logic [31:0] rem_r [0:DIV_STAGES];
  logic [31:0] md_r  [0:DIV_STAGES];
  logic [14:0] tc_r  [0:DIV_STAGES];
  logic        neg_r [0:DIV_STAGES];
  logic        inv_r [0:DIV_STAGES];
  logic        v_r   [0:DIV_STAGES];

  logic [63:0] quo_r;
  logic [14:0] tco_r;
  logic        invo_r, vo_r;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    nq_r[0]  <= num[63] ? 64'(64'd0 - num) : num;
    md_r[0]  <= den[31] ? 32'(32'd0 - den) : den;
    rem_r[0] <= '0;
    neg_r[0] <= num[63] ^ den[31];
    inv_r[0] <= (den == 32'd0);
    tc_r[0]  <= tc_in;
  end

  // remainder stays below the divisor magnitude (at most 2^31)
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [31:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1][30:0], nq_r[k-1][63]};
    assign ge    = (trial >= md_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? 32'(trial - md_r[k-1]) : trial;
      nq_r[k]  <= {nq_r[k-1][62:0], ge};
      md_r[k]  <= md_r[k-1];
      neg_r[k] <= neg_r[k-1];
      inv_r[k] <= inv_r[k-1];
      tc_r[k]  <= tc_r[k-1];
    end
  end

  // sign fix-up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= v_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= neg_r[DIV_STAGES] ? 64'(64'd0 - nq_r[DIV_STAGES]) : nq_r[DIV_STAGES];
    invo_r <= inv_r[DIV_STAGES];
    tco_r  <= tc_r[DIV_STAGES];
  end

  assign out_vld = vo_r;
  assign quo     = quo_r;
  assign inv     = invo_r;
  assign tc_out  = tco_r;

endmodule

### rtl/bsc_back.sv
// Pressure correction terms after the division, trim and saturation.
module bsc_back import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] quo,
  input  logic        inv,
  input  logic [14:0] tc,
  input  bsc_coef_t   coef,
  output logic        out_vld,
  output bsc_out_t    out_data
);

  localparam int SG = 64 + 64 + 15 + 1;
  localparam int SH = 64 + 64 + 15 + 1;

  // step G: P9 * (p >> 13), P8 * p
  logic [63:0]      x_g;
  logic [1:0][63:0] a_g, b_g, p_g;
  logic [SG-1:0]    s_g;
  logic             v_g;
  assign x_g    = asr(quo, 13);
  assign a_g[0] = sx16(coef.p9);
  assign b_g[0] = x_g;
  assign a_g[1] = sx16(coef.p8);
  assign b_g[1] = quo;

  bsc_mul_lo #(.LANES(2), .SW(SG)) u_mul_g (
    .clk, .rst_n, .in_vld(in_vld), .a(a_g), .b(b_g),
    .side_in({quo, x_g, tc, inv}), .out_vld(v_g), .p(p_g), .side_out(s_g)
  );

  // step H: second factor of p >> 13
  logic [0:0][63:0] a_h, b_h, p_h;
  logic [SH-1:0]    s_h;
  logic             v_h;
  assign a_h[0] = p_g[0];
  assign b_h[0] = s_g[79:16];

  bsc_mul_lo #(.LANES(1), .SW(SH)) u_mul_h (
    .clk, .rst_n, .in_vld(v_g), .a(a_h), .b(b_h),
    .side_in({s_g[SG-1:80], asr(p_g[1], 19), s_g[15:0]}),
    .out_vld(v_h), .p(p_h), .side_out(s_h)
  );

  // tail: sum, scale and clamp, trim and clamp
  logic [63:0] sum_r, ps_r, pf_nxt, pt_nxt;
  logic [14:0] tc1_r, tc2_r;
  logic        inv1_r, inv2_r, v1_r, v2_r, v3_r;
  bsc_out_t    out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v_h;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_comb begin
    pf_nxt = asr(sum_r, 8) + {{44{coef.p7[15]}}, coef.p7, 4'b0};
    if ($signed(pf_nxt) < -PRESS_LIM) begin
      pf_nxt = 64'(-PRESS_LIM);
    end else if ($signed(pf_nxt) > PRESS_LIM) begin
      pf_nxt = PRESS_LIM;
    end
  end

  always_comb begin
    pt_nxt = ps_r + sx22(coef.press_trim);
    out_nxt.temperature_centi = tc2_r;
    out_nxt.pressure_invalid  = inv2_r;
    if (inv2_r || $signed(pt_nxt) < 0) begin
      out_nxt.pressure_scaled = '0;
    end else if ($signed(pt_nxt) > PRESS_MAX) begin
      out_nxt.pressure_scaled = PRESS_MAX[24:0];
    end else begin
      out_nxt.pressure_scaled = pt_nxt[24:0];
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= s_h[SH-1:80] + asr(p_h[0], 25) + s_h[79:16];
    tc1_r  <= s_h[15:1];
    inv1_r <= s_h[0];
    ps_r   <= pf_nxt;
    tc2_r  <= tc1_r;
    inv2_r <= inv1_r;
    out_r  <= out_nxt;
  end

  assign out_vld  = v3_r;
  assign out_data = out_r;

endmodule

### rtl/barometric_sensor_compensation_core.sv
// Top level of the barometric temperature and pressure compensation core.
// Takes one raw temperature/pressure pair per clock (start high, busy low) and
// returns for each pair one result marked by a single-cycle out_valid
// strobe: temperature in 0.01 degC and pressure in Pa*256, both trimmed and
// saturated, plus a flag when the pressure divisor is zero. The pipeline has
// six multiply steps for the temperature and the dividend/divisor, a 64-stage
// restoring divider (one quotient bit per stage, plus sign stages), two
// multiply steps for the pressure correction and a three-stage tail. Every
// transaction moves on each cycle; results cannot be held off, so the
// receiver must take each one in the cycle it appears. busy is high only
// while in reset. Calibration registers are written through the cfg_ port at
// any time it is ready; change them only when no transaction is in flight.
module barometric_sensor_compensation_core import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample input
  input  logic                 start,
  output logic                 busy,
  input  bsc_in_t              in_data,
  // results
  output logic                 out_valid,
  output bsc_out_t             out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // calibration and trim registers
  logic [47:0] temp_coef_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_nine_r;
  logic [10:0] temp_trim_r;
  logic [21:0] press_trim_r;

  bsc_coef_t   coef;

  logic        acc;
  logic        f_vld, d_vld;
  logic [63:0] f_num, d_quo;
  logic [31:0] f_den;
  logic [14:0] f_tc, d_tc;
  logic        d_inv;

  assign cfg_ready = 1'b1;
  assign busy      = ~rst_n;
  assign acc       = start & ~busy;

  // index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r  <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_nine_r <= '0;
      temp_trim_r  <= TEMP_TRIM_RST;
      press_trim_r <= PRESS_TRIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_COEF:  temp_coef_r  <= cfg_data[47:0];
        REG_PRESS_LOW:  press_low_r  <= cfg_data;
        REG_PRESS_HIGH: press_high_r <= cfg_data;
        REG_PRESS_NINE: press_nine_r <= cfg_data[15:0];
        REG_TEMP_TRIM:  temp_trim_r  <= cfg_data[10:0];
        REG_PRESS_TRIM: press_trim_r <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  // unpack the calibration words
  assign coef.t1         = temp_coef_r[15:0];
  assign coef.t2         = temp_coef_r[31:16];
  assign coef.t3         = temp_coef_r[47:32];
  assign coef.p1         = press_low_r[15:0];
  assign coef.p2         = press_low_r[31:16];
  assign coef.p3         = press_low_r[47:32];
  assign coef.p4         = press_low_r[63:48];
  assign coef.p5         = press_high_r[15:0];
  assign coef.p6         = press_high_r[31:16];
  assign coef.p7         = press_high_r[47:32];
  assign coef.p8         = press_high_r[63:48];
  assign coef.p9         = press_nine_r;
  assign coef.temp_trim  = temp_trim_r;
  assign coef.press_trim = press_trim_r;

  // temperature, dividend and divisor
  bsc_front u_front (
    .clk, .rst_n,
    .in_vld(acc), .in_data(in_data), .coef(coef),
    .out_vld(f_vld), .num(f_num), .den(f_den), .tc(f_tc)
  );

  // truncating signed division
  bsc_div u_div (
    .clk, .rst_n,
    .in_vld(f_vld), .num(f_num), .den(f_den), .tc_in(f_tc),
    .out_vld(d_vld), .quo(d_quo), .inv(d_inv), .tc_out(d_tc)
  );

  // pressure correction, trim, saturation
  bsc_back u_back (
    .clk, .rst_n,
    .in_vld(d_vld), .quo(d_quo), .inv(d_inv), .tc(d_tc), .coef(coef),
    .out_vld(out_valid), .out_data(out_data)
  );

endmodule

### rtl/bsc_checker.sv
// Port-level checks of the compensation core, bound to the top level.
`include "assert_macros.svh"

module bsc_checker import bsc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input bsc_out_t out_data
);

  `BSC_ASSERT(a_latency, out_valid |-> ($past(start && !busy, CORE_LAT)), "result without a matching transaction")
  `BSC_ASSERT(a_inv_zero, (out_valid && out_data.pressure_invalid) |-> (out_data.pressure_scaled == 25'd0), "invalid pressure not forced to zero")
  `BSC_ASSERT(a_temp_range, out_valid |-> ($signed(out_data.temperature_centi) >= -15'sd4000 && $signed(out_data.temperature_centi) <= 15'sd8500), "temperature outside saturation range")
  `BSC_ASSERT_ANY(a_rst_quiet, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

bind barometric_sensor_compensation_core bsc_checker u_bsc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_data(out_data)
);

### tb/bsc_checker.sv
// Result predictor and scoreboard for the barometric compensation core.
module bsc_scoreboard import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  bsc_in_t              in_data,
  input  logic                 out_valid,
  input  bsc_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [47:0] temp_coef;
  logic [63:0] press_lo, press_hi;
  logic [15:0] press_nine;
  logic [10:0] temp_trim;
  logic [21:0] press_trim;
  bsc_out_t    expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] sext16(input logic [63:0] v);
    return {{48{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [63:0] shr(input logic [63:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] trunc_div(input logic [63:0] num, input logic [63:0] den);
    logic na, nd;
    logic [63:0] ua, ub, q;
    na = num[63];
    nd = den[63];
    ua = na ? -num : num;
    ub = nd ? -den : den;
    q = ua / ub;
    return (na != nd) ? -q : q;
  endfunction

  function automatic bsc_out_t compensate(input bsc_in_t s);
    logic [63:0] adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, d, v2, fine, a, b, p, q1, q2;
    longint tc, ps;
    bsc_out_t r;
    adc_t = {44'd0, s.raw_temperature};
    adc_p = {44'd0, s.raw_pressure};
    t1 = {48'd0, temp_coef[15:0]};
    t2 = sext16(temp_coef[31:16]);
    t3 = sext16(temp_coef[47:32]);
    p1 = {48'd0, press_lo[15:0]};
    p2 = sext16(press_lo[31:16]);
    p3 = sext16(press_lo[47:32]);
    p4 = sext16(press_lo[63:48]);
    p5 = sext16(press_hi[15:0]);
    p6 = sext16(press_hi[31:16]);
    p7 = sext16(press_hi[47:32]);
    p8 = sext16(press_hi[63:48]);
    p9 = sext16({48'd0, press_nine});
    v1 = shr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    v2 = shr(shr(d * d, 12) * t3, 14);
    fine = v1 + v2;
    tc = $signed(shr(fine * 5 + 128, 8));
    tc += $signed({{53{temp_trim[10]}}, temp_trim});
    if (tc < -4000) tc = -4000;
    if (tc > 8500) tc = 8500;
    a = fine - 128000;
    b = a * a * p6;
    b += (a * p5) << 17;
    b += p4 << 35;
    a = shr(a * a * p3, 8) + ((a * p2) << 12);
    a = shr(((64'd1 << 47) + a) * p1, 33);
    r.temperature_centi = tc[14:0];
    if (a == 0) begin
      r.pressure_scaled = '0;
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'd1048576 - adc_p;
      p = trunc_div(((p << 31) - b) * 3125, a);
      q1 = shr(p9 * shr(p, 13) * shr(p, 13), 25);
      q2 = shr(p8 * p, 19);
      p = shr(p + q1 + q2, 8) + (p7 << 4);
      ps = $signed(p);
      if (ps < -(64'sd1 << 40)) ps = -(64'sd1 << 40);
      if (ps > (64'sd1 << 40)) ps = 64'sd1 << 40;
      ps += $signed({{42{press_trim[21]}}, press_trim});
      if (ps < 0) ps = 0;
      if (ps > 33554431) ps = 33554431;
      r.pressure_scaled = ps[24:0];
      r.pressure_invalid = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bsc_out_t want;
    if (!rst_n) begin
      temp_coef <= '0;
      press_lo <= '0;
      press_hi <= '0;
      press_nine <= '0;
      temp_trim <= TEMP_TRIM_RST;
      press_trim <= PRESS_TRIM_RST;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi)
            report_mismatch("temperature", out_data.temperature_centi,
                            want.temperature_centi);
          if (out_data.pressure_scaled !== want.pressure_scaled)
            report_mismatch("pressure", out_data.pressure_scaled, want.pressure_scaled);
          if (out_data.pressure_invalid !== want.pressure_invalid)
            report_mismatch("invalid flag", out_data.pressure_invalid,
                            want.pressure_invalid);
        end
      end
      if (start && !busy) expected_results.push_back(compensate(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEMP_COEF:  temp_coef <= cfg_data[47:0];
          REG_PRESS_LOW:  press_lo <= cfg_data;
          REG_PRESS_HIGH: press_hi <= cfg_data;
          REG_PRESS_NINE: press_nine <= cfg_data[15:0];
          REG_TEMP_TRIM:  temp_trim <= cfg_data[10:0];
          REG_PRESS_TRIM: press_trim <= cfg_data[21:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb.sv
// Stimulus and verdict for the barometric compensation core.
module tb import bsc_pkg::*; ;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  bsc_in_t              in_data = '0;
  logic                 out_valid;
  bsc_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles = 0;

  // watchdog: no transaction for this many cycles means the block hung
  localparam int IDLE_LIMIT = 20 * CORE_LAT + 2000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  barometric_sensor_compensation_core dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bsc_scoreboard checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("barometric_sensor_compensation_core test failed");
      $finish;
    end
  end

  // one register write while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait for every outstanding result, then let the pipeline drain
  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (CORE_LAT + 5) @(posedge clk);
  endtask

  // one sample; start stays high across back-to-back transactions
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp, input bit last);
    start <= 1'b1;
    in_data <= '{raw_temperature: rt, raw_pressure: rp};
    do @(posedge clk); while (busy);
    if (last) start <= 1'b0;
  endtask

  function automatic logic [63:0] rnd64;
    return {$urandom, $urandom};
  endfunction

  // realistic calibration words, so the pressure path reaches mid range
  task automatic load_typical;
    write_reg(REG_TEMP_COEF, {16'(-1000 + $urandom_range(0, 2000)),
                              16'(26000 + $urandom_range(0, 2000)),
                              16'(27000 + $urandom_range(0, 2000))});
    write_reg(REG_PRESS_LOW, {16'(2000 + $urandom_range(0, 2000)),
                              16'(-1000 + $urandom_range(0, 8000)),
                              16'(-11000 + $urandom_range(0, 2000)),
                              16'(35000 + $urandom_range(0, 4000))});
    write_reg(REG_PRESS_HIGH, {16'(-12000 + $urandom_range(0, 2000)),
                               16'(3000 + $urandom_range(0, 2000)),
                               16'(-8 + $urandom_range(0, 16)),
                               16'(-1000 + $urandom_range(0, 2000))});
    write_reg(REG_PRESS_NINE, 64'(6000 + $urandom_range(0, 2000)));
  endtask

  // random burst; mostly sensor-like readings, some full-range noise
  task automatic random_phase(input int count);
    int n, gap;
    n = 0;
    while (n < count) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      for (int k = $urandom_range(1, 20); k > 0 && n < count; k--) begin
        if ($urandom_range(0, 3) != 0)
          send_sample(20'(400000 + $urandom_range(0, 300000)),
                      20'(250000 + $urandom_range(0, 400000)), k == 1 || n == count - 1);
        else
          send_sample(20'($urandom), 20'($urandom), k == 1 || n == count - 1);
        n++;
      end
    end
  endtask

  initial begin
    logic [19:0] corner[4];
    corner = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset coefficients are zero: divisor zero, invalid flag
    for (int i = 0; i < 4; i++) send_sample(corner[i], corner[3 - i], i == 3);
    drain();

    // typical calibration, extreme readings and trims
    load_typical();
    write_reg(REG_TEMP_TRIM, 64'(11'(1000)));
    write_reg(REG_PRESS_TRIM, 64'(22'(1048576)));
    for (int i = 0; i < 16; i++) send_sample(corner[i % 4], corner[i / 4], i == 15);
    drain();
    write_reg(REG_TEMP_TRIM, 64'(11'(-1000)));
    write_reg(REG_PRESS_TRIM, 64'(22'(-1048576)));
    random_phase(100);
    drain();

    // extreme calibration patterns, including wide wrap-around
    write_reg(REG_TEMP_COEF, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
    write_reg(REG_PRESS_NINE, 64'h8000);
    write_reg(8'd9, rnd64()); // out-of-range index, ignored
    random_phase(100);
    drain();

    // phases of random calibration and trims
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 0) begin
        write_reg(REG_TEMP_COEF, rnd64());
        write_reg(REG_PRESS_LOW, rnd64());
        write_reg(REG_PRESS_HIGH, rnd64());
        write_reg(REG_PRESS_NINE, rnd64());
      end else begin
        load_typical();
      end
      write_reg(REG_TEMP_TRIM, 64'(11'(-1000 + $urandom_range(0, 2000))));
      write_reg(REG_PRESS_TRIM, 64'(22'(-1048576 + $urandom_range(0, 2097152))));
      random_phase(100);
      drain();
    end

    if (fail_count == 0) begin
      $display("barometric_sensor_compensation_core test passed");
    end else begin
      $display("barometric_sensor_compensation_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bsc_pkg.sv
rtl/bsc_mul_lo.sv
rtl/bsc_front.sv
rtl/bsc_div.sv
rtl/bsc_back.sv
rtl/barometric_sensor_compensation_core.sv
rtl/bsc_checker.sv
tb/bsc_checker.sv
tb/tb.sv
